/* sv/hsvs_pkg.sv */
// shared types for the hsv sector to rgb converter
package hsvs_pkg;

  typedef enum logic [2:0] {
    SEC_RY = 3'd0,
    SEC_YG = 3'd1,
    SEC_GC = 3'd2,
    SEC_CB = 3'd3,
    SEC_BM = 3'd4,
    SEC_MR = 3'd5
  } sector_t;

endpackage

/* sv/hsv_sector_to_rgb_converter.sv */
// top level of the hsv sector to rgb converter
// Converts one pixel per clock while the output is not held, from hue,
// saturation and intensity (unsigned fixed point with FRAC_BITS fraction
// bits, 1.0 = 1 << FRAC_BITS, values above 1.0 clamp to 1.0) to an 8-bit
// rgb triple. Sustained rate is one transfer per cycle on both sides while
// rgb_ready stays high. An input transfer passes one front register after
// the min-channel multiply, the four-entry queue, one register after the
// ramp multiply and the output register before its result is offered. The
// queue lets the front keep accepting pixels while the output is held.
module hsv_sector_to_rgb_converter
  import hsvs_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pix_valid,
  output logic                 pix_ready,
  input  logic [FRAC_BITS-1:0] hue,
  input  logic [FRAC_BITS:0]   saturation,
  input  logic [FRAC_BITS:0]   intensity,
  output logic                 rgb_valid,
  input  logic                 rgb_ready,
  output logic [7:0]           red,
  output logic [7:0]           green,
  output logic [7:0]           blue
);

  localparam int F       = FRAC_BITS;
  localparam int Q_DEPTH = 4;
  localparam int Q_WIDTH = 3 + F + (F + 1) + (2 * F + 2);

  logic               f_valid;
  logic               f_ready;
  sector_t            f_sector;
  logic [F-1:0]       f_frac;
  logic [F:0]         f_value;
  logic [2*F+1:0]     f_lo_prod;

  logic               q_valid;
  logic               q_ready;
  logic [Q_WIDTH-1:0] q_wr_data;
  logic [Q_WIDTH-1:0] q_rd_data;
  sector_t            q_sector;
  logic [F-1:0]       q_frac;
  logic [F:0]         q_value;
  logic [2*F+1:0]     q_lo_prod;

  hsvs_front #(.FRAC_BITS(F)) u_front (
    .clk         (clk),
    .rst         (rst),
    .pix_valid   (pix_valid),
    .pix_ready   (pix_ready),
    .hue         (hue),
    .saturation  (saturation),
    .intensity   (intensity),
    .cls_valid   (f_valid),
    .cls_ready   (f_ready),
    .cls_sector  (f_sector),
    .cls_frac    (f_frac),
    .cls_value   (f_value),
    .cls_lo_prod (f_lo_prod)
  );

  assign q_wr_data = {f_sector, f_frac, f_value, f_lo_prod};

  hsvs_queue #(.WIDTH(Q_WIDTH), .DEPTH(Q_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (q_wr_data),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_rd_data)
  );

  assign q_sector  = sector_t'(q_rd_data[Q_WIDTH-1 -: 3]);
  assign q_frac    = q_rd_data[Q_WIDTH-4 -: F];
  assign q_value   = q_rd_data[2*F+2 +: F+1];
  assign q_lo_prod = q_rd_data[2*F+1:0];

  hsvs_back #(.FRAC_BITS(F)) u_back (
    .clk         (clk),
    .rst         (rst),
    .cls_valid   (q_valid),
    .cls_ready   (q_ready),
    .cls_sector  (q_sector),
    .cls_frac    (q_frac),
    .cls_value   (q_value),
    .cls_lo_prod (q_lo_prod),
    .rgb_valid   (rgb_valid),
    .rgb_ready   (rgb_ready),
    .red         (red),
    .green       (green),
    .blue        (blue)
  );

endmodule

/* sv/hsvs_front.sv */
// front stage: input clamp, sector split and min-channel product
module hsvs_front
  import hsvs_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   pix_valid,
  output logic                   pix_ready,
  input  logic [FRAC_BITS-1:0]   hue,
  input  logic [FRAC_BITS:0]     saturation,
  input  logic [FRAC_BITS:0]     intensity,
  output logic                   cls_valid,
  input  logic                   cls_ready,
  output sector_t                cls_sector,
  output logic [FRAC_BITS-1:0]   cls_frac,
  output logic [FRAC_BITS:0]     cls_value,
  output logic [2*FRAC_BITS+1:0] cls_lo_prod
);

  localparam int F = FRAC_BITS;
  localparam logic [F:0] ONE_FX = (F+1)'(1) << F;

  logic           adv;
  logic [F:0]     sat_c;
  logic [F:0]     val_c;
  logic [F:0]     one_minus_s;
  logic [F+2:0]   hue6;
  logic [2*F+1:0] lo_prod_next;

  always_comb begin
    sat_c        = (saturation > ONE_FX) ? ONE_FX : saturation;
    val_c        = (intensity > ONE_FX) ? ONE_FX : intensity;
    one_minus_s  = ONE_FX - sat_c;
    hue6         = {1'b0, hue, 2'b00} + {2'b00, hue, 1'b0};
    lo_prod_next = {{(F+1){1'b0}}, val_c} * {{(F+1){1'b0}}, one_minus_s};
  end

  assign adv       = !cls_valid || cls_ready;
  assign pix_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      cls_valid <= 1'b0;
    end else if (adv) begin
      cls_valid <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && pix_valid) begin
      cls_sector  <= sector_t'(hue6[F+2:F]);
      cls_frac    <= hue6[F-1:0];
      cls_value   <= val_c;
      cls_lo_prod <= lo_prod_next;
    end
  end

endmodule

/* sv/hsvs_queue.sv */
// short queue between the front and back stages
module hsvs_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign wr_ready = count != CNT_W'(DEPTH);
  assign rd_valid = count != '0;
  assign rd_data  = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + CNT_W'(1))
    else $error("queue count missed a push");

  assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> count == $past(count) - CNT_W'(1))
    else $error("queue count missed a pop");

endmodule

/* sv/hsvs_back.sv */
// back stages: ramp product, sector select and byte scaling
module hsvs_back
  import hsvs_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cls_valid,
  output logic                   cls_ready,
  input  sector_t                cls_sector,
  input  logic [FRAC_BITS-1:0]   cls_frac,
  input  logic [FRAC_BITS:0]     cls_value,
  input  logic [2*FRAC_BITS+1:0] cls_lo_prod,
  output logic                   rgb_valid,
  input  logic                   rgb_ready,
  output logic [7:0]             red,
  output logic [7:0]             green,
  output logic [7:0]             blue
);

  localparam int F = FRAC_BITS;
  localparam logic [2*F+1:0] HALF_LO = (2*F+2)'(1) << (F-1);
  localparam logic [2*F:0]   HALF_RP = (2*F+1)'(1) << (F-1);
  localparam logic [F+8:0]   HALF_BY = (F+9)'(1) << (F-1);

  function automatic logic [7:0] to_byte(input logic [F:0] c);
    logic [F+8:0] scaled;
    logic [F+8:0] rounded;
    scaled  = {c, 8'h00} - {8'h00, c};
    rounded = scaled + HALF_BY;
    to_byte = (rounded[F+8:F] > 9'd255) ? 8'hff : rounded[F+7:F];
  endfunction

  // ramp stage
  logic           a_valid;
  logic           a_adv;
  sector_t        a_sector;
  logic [F:0]     a_value;
  logic [F:0]     a_lo;
  logic [2*F:0]   a_ramp_prod;
  logic [2*F+1:0] lo_sum;
  logic [F:0]     lo_next;
  logic [F:0]     diff;
  logic [2*F:0]   ramp_prod_next;

  // output stage
  logic           b_adv;
  logic [2*F:0]   ramp_sum;
  logic [F:0]     ramp;
  logic [F:0]     up;
  logic [F:0]     down;
  logic [F:0]     r_c;
  logic [F:0]     g_c;
  logic [F:0]     b_c;

  always_comb begin
    lo_sum         = cls_lo_prod + HALF_LO;
    lo_next        = lo_sum[2*F:F];
    diff           = cls_value - lo_next;
    ramp_prod_next = {{F{1'b0}}, diff} * {{(F+1){1'b0}}, cls_frac};
  end

  assign b_adv     = !rgb_valid || rgb_ready;
  assign a_adv     = !a_valid || b_adv;
  assign cls_ready = a_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_adv) begin
      a_valid <= cls_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv && cls_valid) begin
      a_sector    <= cls_sector;
      a_value     <= cls_value;
      a_lo        <= lo_next;
      a_ramp_prod <= ramp_prod_next;
    end
  end

  always_comb begin
    ramp_sum = a_ramp_prod + HALF_RP;
    ramp     = ramp_sum[2*F:F];
    up       = a_lo + ramp;
    down     = a_value - ramp;
    unique case (a_sector)
      SEC_RY: begin
        r_c = a_value; g_c = up;      b_c = a_lo;
      end
      SEC_YG: begin
        r_c = down;    g_c = a_value; b_c = a_lo;
      end
      SEC_GC: begin
        r_c = a_lo;    g_c = a_value; b_c = up;
      end
      SEC_CB: begin
        r_c = a_lo;    g_c = down;    b_c = a_value;
      end
      SEC_BM: begin
        r_c = up;      g_c = a_lo;    b_c = a_value;
      end
      default: begin
        r_c = a_value; g_c = a_lo;    b_c = down;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rgb_valid <= 1'b0;
    end else if (b_adv) begin
      rgb_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv && a_valid) begin
      red   <= to_byte(r_c);
      green <= to_byte(g_c);
      blue  <= to_byte(b_c);
    end
  end

  assert property (@(posedge clk) disable iff (rst) a_valid |-> a_lo <= a_value)
    else $error("min channel above intensity");

endmodule
